>>> rtl/cone_max_filter_defines.svh
// ----------------------------------------------------------------------------
// cone max filter assertion macros
// shared property forms, clocked on aclk and off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef CONE_MAX_FILTER_DEFINES_SVH
`define CONE_MAX_FILTER_DEFINES_SVH

// same-cycle implication
`define CMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cmf_pkg.sv
// ----------------------------------------------------------------------------
// cmf_pkg
// shared sizes, types and control bundle for the cone max filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmf_pkg;

    localparam int MAX_SIZE    = 64;
    localparam int VALUE_WIDTH = 16;
    localparam int ADDR_W      = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SIZE_W      = 7;
    localparam int SIZE_RESET  = 8;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic [SIZE_W-1:0]             size_t;

    // column and position flags of the request held in the compute stage
    typedef struct packed {
        addr_t col;
        logic  first_col;
        logic  has_right;
        logic  below;
        logic  row_end;
        logic  frame_end;
    } s1_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/cmf_ram.sv
// ----------------------------------------------------------------------------
// cmf_ram
// simple dual-port line memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/cone_max_filter.sv
// ----------------------------------------------------------------------------
// cone_max_filter
// downward cone maximum over a square matrix, streamed one element per cycle
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries matrix elements, bottom row first, left to right in a
//   row; m_ channel returns one cone maximum per element in the same order,
//   flagged with m_row_end at the last column and m_frame_end at the last
//   element of the matrix. Both are valid/ready channels.
//   cfg_wr_en/cfg_wr_data set the matrix size (0 acts as 1, above 64 as 64)
//   and restart the frame; write it only while the block is empty.
//   An accepted element is registered in the compute stage, its result then
//   in the output register, which drives m_ until the result is taken.
//   Throughput is one element per cycle while m_ is taken: an element costs
//   one line memory read on accept, ahead of the compare, and one write.
//   A stalled receiver holds the result in the output register; the compute
//   stage keeps one more element, then s_ready drops until m_ is taken.
//   Reset (synchronous, aresetn low) empties the pipeline, sets the size to
//   8 and starts at the first element of a bottom row. The line memory
//   needs no clearing: the bottom row writes every entry of the row before it is used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cone_max_filter_defines.svh"

module cone_max_filter (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [6:0]           cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [15:0]   s_element_value,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [15:0]        m_cone_max,
    output logic                      m_row_end,
    output logic                      m_frame_end
);

    // size and position
    cmf_pkg::size_t    size_reg, size_next;
    cmf_pkg::addr_t    size_m1;
    cmf_pkg::addr_t    col_reg, col_next;
    cmf_pkg::addr_t    row_reg, row_next;
    logic              accept;
    logic              in_row_end;

    // compute stage
    logic              s1_valid_reg, s1_valid_next;
    cmf_pkg::value_t   s1_value_reg;
    cmf_pkg::s1_ctrl_t s1_ctrl_reg, s1_ctrl_next;
    logic              s1_adv;
    cmf_pkg::value_t   here, right, best;
    cmf_pkg::value_t   here_reg, left_reg, row0_reg;
    cmf_pkg::value_t   fwd_data_reg;
    logic              fwd_valid_reg;
    cmf_pkg::addr_t    rd_addr;
    cmf_pkg::value_t   ram_rd_data;

    // output register
    logic              m_valid_reg, m_valid_next;
    cmf_pkg::value_t   m_cone_max_reg;
    logic              m_row_end_reg, m_frame_end_reg;

    always_comb begin
        if (size_reg == '0) begin
            size_m1 = '0;
        end else if (size_reg > cmf_pkg::SIZE_W'(cmf_pkg::MAX_SIZE)) begin
            size_m1 = cmf_pkg::ADDR_W'(cmf_pkg::MAX_SIZE - 1);
        end else begin
            size_m1 = cmf_pkg::ADDR_W'(size_reg - 1'b1);
        end
    end

    assign s1_adv     = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_adv;
    assign accept     = s_valid && s_ready;
    assign in_row_end = (col_reg == size_m1);
    assign rd_addr    = col_reg + 1'b1;

    // position counters and size
    always_comb begin
        size_next = size_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (cfg_wr_en) begin
            size_next = cfg_wr_data;
            col_next  = '0;
            row_next  = '0;
        end else if (accept) begin
            if (in_row_end) begin
                col_next = '0;
                row_next = (row_reg == size_m1) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        s1_ctrl_next.col       = col_reg;
        s1_ctrl_next.first_col = (col_reg == '0);
        s1_ctrl_next.has_right = !in_row_end;
        s1_ctrl_next.below     = (row_reg != '0);
        s1_ctrl_next.row_end   = in_row_end;
        s1_ctrl_next.frame_end = in_row_end && (row_reg == size_m1);
    end

    cmf_ram #(
        .DEPTH (cmf_pkg::MAX_SIZE),
        .WIDTH (cmf_pkg::VALUE_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_ctrl_reg.col),
        .wr_data (best),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // old entries of this column and the one to the right
    assign here  = s1_ctrl_reg.first_col ? row0_reg : here_reg;
    assign right = fwd_valid_reg ? fwd_data_reg : ram_rd_data;

    always_comb begin
        best = s1_value_reg;
        if (s1_ctrl_reg.below) begin
            if (!s1_ctrl_reg.first_col && left_reg > best) begin
                best = left_reg;
            end
            if (here > best) begin
                best = here;
            end
            if (s1_ctrl_reg.has_right && right > best) begin
                best = right;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= cmf_pkg::SIZE_W'(cmf_pkg::SIZE_RESET);
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            left_reg      <= '0;
        end else begin
            size_reg     <= size_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (accept) begin
                // a same-cycle write to the entry being read wins
                fwd_valid_reg <= s1_adv && (s1_ctrl_reg.col == rd_addr);
            end
            if (cfg_wr_en) begin
                left_reg <= '0;
            end else if (s1_adv) begin
                left_reg <= s1_ctrl_reg.row_end ? '0 : here;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_value_reg <= s_element_value;
            s1_ctrl_reg  <= s1_ctrl_next;
            fwd_data_reg <= best;
        end
        if (s1_adv) begin
            here_reg        <= right;
            m_cone_max_reg  <= best;
            m_row_end_reg   <= s1_ctrl_reg.row_end;
            m_frame_end_reg <= s1_ctrl_reg.frame_end;
            if (s1_ctrl_reg.first_col) begin
                row0_reg <= best;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_cone_max  = m_cone_max_reg;
    assign m_row_end   = m_row_end_reg;
    assign m_frame_end = m_frame_end_reg;

    `CMF_ASSERT_NOW(a_frame_end_closes_row, m_valid && m_frame_end, m_row_end, "frame end without row end")
    `CMF_ASSERT_NOW(a_best_not_below_input, s1_valid_reg, best >= s1_value_reg, "cone max below element")
    `CMF_ASSERT_NOW(a_stall_blocks_input, s1_valid_reg && m_valid_reg && !m_ready, !s_ready, "request taken into full pipeline")
    `CMF_ASSERT_NEXT(a_frame_wraps, accept && !cfg_wr_en && in_row_end && (row_reg == size_m1), (col_reg == '0) && (row_reg == '0), "frame did not wrap")

endmodule

`default_nettype wire
